[src/assert_macros.svh]
// assertion macros used by the pool controller
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked at every edge while out of reset
`define BFRP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define BFRP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/bfrp_pkg.sv]
// types, widths and constants of the best-fit retention pool
// no dependencies
package bfrp_pkg;

  localparam int CAP_W     = 25;
  localparam int TAG_W     = 32;
  localparam int SLOTS_DEF = 256;
  localparam int DATA_W    = 64;

  localparam logic [CAP_W-1:0] CAP_RESET = 25'd2097152;

  localparam logic CMD_TAKE = 1'b0;
  localparam logic CMD_PUT  = 1'b1;

  typedef struct packed {
    logic latch;
    logic rd_en;
    logic commit;
  } ctl_cmd_t;

  typedef struct packed {
    logic cap_zero;
  } ctl_stat_t;

endpackage

[src/bfrp_ram.sv]
// generic single-port ram with registered read
// no dependencies
module bfrp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

[src/bfrp_ctrl.sv]
// controller: request sequencing, slot scan counter, result handshake
// depends on bfrp_pkg and assert_macros.svh
`include "assert_macros.svh"

module bfrp_ctrl #(
  parameter int SLOTS = 256
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  input  bfrp_pkg::ctl_stat_t      stat,
  output bfrp_pkg::ctl_cmd_t       cmd,
  output logic [$clog2(SLOTS)-1:0] scan_idx
);
  import bfrp_pkg::*;

  localparam int IW = $clog2(SLOTS);
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT
  } state_t;

  state_t        state_r, state_nxt;
  logic [IW-1:0] cnt_r, cnt_nxt;
  logic          out_valid_r, out_valid_nxt;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign scan_idx   = cnt_r;

  always_comb begin
    cmd.latch  = in_tready && in_tvalid;
    cmd.rd_en  = (state_r == ST_SCAN);
    cmd.commit = (state_r == ST_COMMIT) && (!out_valid_r || out_tready);
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cnt_nxt   = '0;
          state_nxt = stat.cap_zero ? ST_COMMIT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        cnt_nxt = cnt_r + IW'(1);
        if (cnt_r == LAST_IDX) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (cmd.commit) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `BFRP_ASSERT(a_one_at_a_time, clk, rst_n, cmd.latch |=> !in_tready, "item accepted while busy")
  `BFRP_ASSERT(a_no_overwrite, clk, rst_n, cmd.commit |-> (!out_valid_r || out_tready), "result overwritten")
  `BFRP_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid_r, "result after reset")

endmodule

[src/bfrp_dp.sv]
// datapath: slot valid bits, slot ram, best-fit and free-slot tracking, totals
// depends on bfrp_pkg and bfrp_ram
module bfrp_dp #(
  parameter int SLOTS = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [bfrp_pkg::CAP_W-1:0]    cfg_wdata,
  input  logic                          req_cmd,
  input  logic [bfrp_pkg::CAP_W-1:0]    req_size,
  input  logic [bfrp_pkg::TAG_W-1:0]    req_tag,
  input  bfrp_pkg::ctl_cmd_t            cmd,
  input  logic [$clog2(SLOTS)-1:0]      scan_idx,
  output bfrp_pkg::ctl_stat_t           stat,
  output logic                          res_ok,
  output logic [bfrp_pkg::TAG_W-1:0]    res_tag,
  output logic [bfrp_pkg::CAP_W-1:0]    res_held
);
  import bfrp_pkg::*;

  localparam int IW = $clog2(SLOTS);
  localparam int RW = TAG_W + CAP_W;

  logic [CAP_W-1:0] cap_r;
  logic [CAP_W-1:0] held_r, held_nxt;
  logic [SLOTS-1:0] valid_r;
  logic             cmd_r;
  logic [CAP_W-1:0] size_r;
  logic [TAG_W-1:0] tag_r;

  logic             cmp_vld_r;
  logic [IW-1:0]    cmp_idx_r;
  logic             vbit_r;

  logic             best_found_r;
  logic [IW-1:0]    best_idx_r;
  logic [CAP_W-1:0] best_pages_r;
  logic [TAG_W-1:0] best_tag_r;
  logic             empty_found_r;
  logic [IW-1:0]    empty_idx_r;

  logic [RW-1:0]    rd_data;
  logic [CAP_W-1:0] rd_pages;
  logic [TAG_W-1:0] rd_tag;
  logic             fits;
  logic [CAP_W:0]   put_sum;
  logic             take_hit;
  logic             put_ok;
  logic             ram_en;
  logic [IW-1:0]    ram_addr;

  assign stat.cap_zero = (cap_r == '0);

  assign rd_pages = rd_data[CAP_W-1:0];
  assign rd_tag   = rd_data[RW-1:CAP_W];

  // best fit window: size <= pages <= 2 * size, strictly smaller than current best
  assign fits = vbit_r && (rd_pages >= size_r)
             && ({1'b0, rd_pages} <= {size_r, 1'b0})
             && (!best_found_r || (rd_pages < best_pages_r));

  assign put_sum  = {1'b0, held_r} + {1'b0, size_r};
  assign take_hit = (cmd_r == CMD_TAKE) && best_found_r && !stat.cap_zero;
  assign put_ok   = (cmd_r == CMD_PUT) && empty_found_r && !stat.cap_zero
                 && (put_sum <= {1'b0, cap_r});

  assign ram_en   = cmd.rd_en || (cmd.commit && put_ok);
  assign ram_addr = cmd.commit ? empty_idx_r : scan_idx;

  bfrp_ram #(
    .WIDTH (RW),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (cmd.commit && put_ok),
    .addr  (ram_addr),
    .wdata ({tag_r, size_r}),
    .rdata (rd_data)
  );

  always_comb begin
    held_nxt = held_r;
    if (take_hit) begin
      held_nxt = held_r - best_pages_r;
    end else if (put_ok) begin
      held_nxt = put_sum[CAP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r         <= CAP_RESET;
      held_r        <= '0;
      valid_r       <= '0;
      cmp_vld_r     <= 1'b0;
      best_found_r  <= 1'b0;
      empty_found_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      cmp_vld_r <= cmd.rd_en;
      if (cmd.latch) begin
        best_found_r  <= 1'b0;
        empty_found_r <= 1'b0;
      end else if (cmp_vld_r) begin
        if (fits) begin
          best_found_r <= 1'b1;
        end
        if (!vbit_r && !empty_found_r) begin
          empty_found_r <= 1'b1;
        end
      end
      if (cmd.commit) begin
        held_r <= held_nxt;
        if (take_hit) begin
          valid_r[best_idx_r] <= 1'b0;
        end else if (put_ok) begin
          valid_r[empty_idx_r] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cmd_r  <= req_cmd;
      size_r <= req_size;
      tag_r  <= req_tag;
    end
    if (cmd.rd_en) begin
      cmp_idx_r <= scan_idx;
      vbit_r    <= valid_r[scan_idx];
    end
    if (cmp_vld_r && !cmd.latch) begin
      if (fits) begin
        best_idx_r   <= cmp_idx_r;
        best_pages_r <= rd_pages;
        best_tag_r   <= rd_tag;
      end
      if (!vbit_r && !empty_found_r) begin
        empty_idx_r <= cmp_idx_r;
      end
    end
    if (cmd.commit) begin
      res_ok   <= take_hit || put_ok;
      res_tag  <= take_hit ? best_tag_r : '0;
      res_held <= held_nxt;
    end
  end

endmodule

[src/best_fit_retention_pool_top.sv]
// top level of the best-fit retention pool
// depends on bfrp_pkg, bfrp_ctrl, bfrp_dp, bfrp_ram
//
// channel   dir  tdata (low bit up)             tuser
// in_       in   size_pages[24:0] block_tag     cmd (0 take, 1 put)
// out_      out  found_tag[31:0] pages_held     ok
// cfg_      in   cfg_wdata = pool_cap_pages     -
//
// one item at a time; the slot ram is scanned one slot per cycle,
// and a zero cap skips the scan
// the next item is accepted while a result still waits on out_
// a stalled out_ holds the next item in its commit cycle
// reset empties the pool and sets the cap to 2097152 pages
module best_fit_retention_pool_top #(
  parameter int SLOTS = bfrp_pkg::SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [bfrp_pkg::CAP_W-1:0]    cfg_wdata,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [bfrp_pkg::DATA_W-1:0]   in_tdata,  // size_pages[24:0], block_tag[56:25]
  input  logic                          in_tuser,  // cmd
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [bfrp_pkg::DATA_W-1:0]   out_tdata, // found_tag[31:0], pages_held[56:32]
  output logic                          out_tuser  // ok
);
  import bfrp_pkg::*;

  ctl_cmd_t               cmd;
  ctl_stat_t              stat;
  logic [$clog2(SLOTS)-1:0] scan_idx;
  logic [TAG_W-1:0]       res_tag;
  logic [CAP_W-1:0]       res_held;

  bfrp_ctrl #(
    .SLOTS (SLOTS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd),
    .scan_idx   (scan_idx)
  );

  bfrp_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req_cmd   (in_tuser),
    .req_size  (in_tdata[CAP_W-1:0]),
    .req_tag   (in_tdata[CAP_W+TAG_W-1:CAP_W]),
    .cmd       (cmd),
    .scan_idx  (scan_idx),
    .stat      (stat),
    .res_ok    (out_tuser),
    .res_tag   (res_tag),
    .res_held  (res_held)
  );

  assign out_tdata = {{(DATA_W-TAG_W-CAP_W){1'b0}}, res_held, res_tag};

endmodule
